/* hdl/qvr_pkg.sv */
// Shared types, widths and the CORDIC arctangent table for the quaternion rotator.
package qvr_pkg;

  localparam int CW          = 34;  // CORDIC x, y, z datapath width (Q2.30 plus headroom)
  localparam int QW          = 18;  // quaternion component width, Q1.14
  localparam int DW          = 16;  // input field width
  localparam int OW          = 18;  // output field width
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  // operands that travel along the CORDIC row untouched
  typedef struct packed {
    logic signed [DW-1:0] ax;
    logic signed [DW-1:0] ay;
    logic signed [DW-1:0] az;
    logic signed [DW-1:0] vx;
    logic signed [DW-1:0] vy;
    logic signed [DW-1:0] vz;
  } carry_t;

  typedef struct packed {
    logic                 valid;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    carry_t               pl;
  } cord_t;

endpackage

/* hdl/qvr_cordic_cell.sv */
// One rotation-mode CORDIC micro-rotation, registered.
module qvr_cordic_cell import qvr_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  cord_t din,
  output cord_t dout
);

  localparam logic signed [CW-1:0] ATAN = CW'($signed({1'b0, ATAN_TABLE[IDX]}));

  logic signed [CW-1:0] dx, dy;
  cord_t dout_next;

  assign dx = din.y >>> IDX;
  assign dy = din.x >>> IDX;

  always_comb begin
    dout_next = din;
    if (!din.z[CW-1]) begin
      dout_next.x = din.x - dx;
      dout_next.y = din.y + dy;
      dout_next.z = din.z - ATAN;
    end else begin
      dout_next.x = din.x + dx;
      dout_next.y = din.y - dy;
      dout_next.z = din.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule

/* hdl/qvr_quat_mult.sv */
// Quaternion build, two Hamilton products, rounding and saturation.
module qvr_quat_mult import qvr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  cord_t                din,
  output logic                 out_valid,
  output logic signed [OW-1:0] rot_x,
  output logic signed [OW-1:0] rot_y,
  output logic signed [OW-1:0] rot_z
);

  localparam int PW = DW + CW;   // axis * sin
  localparam int TW = 37;        // q * v sums
  localparam int RW = 58;        // t * conj(q) sums

  // stage 1: quaternion
  logic                 v1;
  logic signed [QW-1:0] q0, q1, q2, q3;
  logic signed [DW-1:0] vx1, vy1, vz1;
  logic signed [PW-1:0] pa, pb, pc;
  logic signed [CW-1:0] cr;

  assign pa = (din.pl.ax * din.y) + PW'(64'sd536870912);
  assign pb = (din.pl.ay * din.y) + PW'(64'sd536870912);
  assign pc = (din.pl.az * din.y) + PW'(64'sd536870912);
  assign cr = din.x + CW'(34'sd32768);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q0  <= QW'(cr >>> 16);
      q1  <= QW'(pa >>> 30);
      q2  <= QW'(pb >>> 30);
      q3  <= QW'(pc >>> 30);
      vx1 <= din.pl.vx;
      vy1 <= din.pl.vy;
      vz1 <= din.pl.vz;
    end
  end

  // stage 2: t = q * (0, v)
  logic                 v2;
  logic signed [TW-1:0] t0, t1, t2, t3;
  logic signed [QW-1:0] s0, s1, s2, s3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0 <= TW'(-(q1 * vx1) - (q2 * vy1) - (q3 * vz1));
      t1 <= TW'((q0 * vx1) + (q2 * vz1) - (q3 * vy1));
      t2 <= TW'((q0 * vy1) - (q1 * vz1) + (q3 * vx1));
      t3 <= TW'((q0 * vz1) + (q1 * vy1) - (q2 * vx1));
      s0 <= q0;
      s1 <= q1;
      s2 <= q2;
      s3 <= q3;
    end
  end

  // stage 3: r = t * conj(q), vector part only
  logic                 v3;
  logic signed [RW-1:0] r1, r2, r3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1 <= RW'(-(t0 * s1) + (t1 * s0) - (t2 * s3) + (t3 * s2));
      r2 <= RW'(-(t0 * s2) + (t2 * s0) + (t1 * s3) - (t3 * s1));
      r3 <= RW'(-(t0 * s3) + (t3 * s0) - (t1 * s2) + (t2 * s1));
    end
  end

  // stage 4: round Q28 to integer and clamp to 18 bits
  function automatic logic signed [OW-1:0] rnd_sat(input logic signed [RW-1:0] r);
    logic signed [RW-1:0] sh;
    sh = (r + RW'(58'sd134217728)) >>> 28;
    if (sh > RW'(58'sd131071))       rnd_sat = 18'sd131071;
    else if (sh < -RW'(58'sd131072)) rnd_sat = -18'sd131072;
    else                             rnd_sat = sh[OW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_x <= rnd_sat(r1);
      rot_y <= rnd_sat(r2);
      rot_z <= rnd_sat(r3);
    end
  end

endmodule

/* hdl/quaternion_vector_rotation.sv */
// Top level: quaternion axis-angle rotation of a 3-D vector, fully pipelined.
// Takes one transfer per cycle. A row of CORDIC_STAGES registered cells, capped at
// ATAN_ENTRIES, forms cos and sin of the half angle, then four
// stages build q, form t = q*v, form r = t*conj(q), and round and clamp to 18
// bits. The whole pipeline advances together whenever the output register is
// empty or its result is being taken, so in_ready follows out_ready with no
// bubble; a stalled output holds every stage. No state is kept between items.
module quaternion_vector_rotation import qvr_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [DW-1:0] axis_x,
  input  logic signed [DW-1:0] axis_y,
  input  logic signed [DW-1:0] axis_z,
  input  logic signed [DW-1:0] vec_x,
  input  logic signed [DW-1:0] vec_y,
  input  logic signed [DW-1:0] vec_z,
  input  logic signed [DW-1:0] angle,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [OW-1:0] rot_x,
  output logic signed [OW-1:0] rot_y,
  output logic signed [OW-1:0] rot_z
);

  // stages beyond the arctangent table are not built
  localparam int unsigned NCELL = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES
                                                                  : CORDIC_STAGES;

  logic  en;
  cord_t chain [NCELL+1];

  // global pipeline enable
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // row entry: half angle in units of 2^32 per turn, gain-compensated x
  always_comb begin
    chain[0].valid = in_valid;
    chain[0].x     = CORDIC_GAIN;
    chain[0].y     = '0;
    chain[0].z     = CW'($signed({angle, 15'b0}));
    chain[0].pl.ax = axis_x;
    chain[0].pl.ay = axis_y;
    chain[0].pl.az = axis_z;
    chain[0].pl.vx = vec_x;
    chain[0].pl.vy = vec_y;
    chain[0].pl.vz = vec_z;
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    qvr_cordic_cell #(.IDX(i)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  qvr_quat_mult u_qm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .din       (chain[NCELL]),
    .out_valid (out_valid),
    .rot_x     (rot_x),
    .rot_y     (rot_y),
    .rot_z     (rot_z)
  );

  // reset leaves no result pending
  a_rst_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("out_valid set right after reset");

  // an empty output stage never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // an accepted transfer enters the first cell
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> chain[1].valid)
    else $error("accepted transfer lost at row entry");

endmodule
